>>> rtl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg: shared types and constants of the delivery-rate sampler.
// Holds the opcode and status codes and the word passed from front to back.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int SlotCountDefault = 256;
    localparam int W48 = 48;
    localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [23:0] BitsPerSec = 24'd8000000;

    typedef enum logic [1:0] {
        OP_SENT = 2'd0,
        OP_ACKED = 2'd1,
        OP_LOST = 2'd2,
        OP_APPLIM = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_BUSY = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic        need_rate;
        logic        send_inf;
        logic [47:0] send_bytes;
        logic [47:0] send_delta;
        logic [47:0] ack_bytes;
        logic [47:0] ack_delta;
        logic [1:0]  status;
        logic [47:0] rtt;
        logic        app_lim;
    } job_t;

endpackage

>>> rtl/drs_front.sv
// ----------------------------------------------------------------------------
// drs_front: accepts events and keeps the running totals and slot store.
// Reads the slot into registers, then classifies the event and writes a job.
// ----------------------------------------------------------------------------
module drs_front #(
    parameter int SLOT_COUNT = drs_pkg::SlotCountDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [215:0]       s_tdata,
    output logic               job_valid,
    input  logic               job_ready,
    output drs_pkg::job_t      job
);
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_PUSH = 3'b100
    } fstate_t;

    // The slot index is reduced modulo the slot count through a constant table.
    function automatic logic [SW-1:0] slot_of(input logic [7:0] idx);
        logic [SW-1:0] res;
        res = '0;
        for (int i = 0; i < 256; i++) begin
            if (idx == 8'(i)) res = SW'(i % SLOT_COUNT);
        end
        return res;
    endfunction

    fstate_t state_reg, state_next;

    logic [47:0] sent_tot_reg, acked_tot_reg, lost_tot_reg, sent_at_ack_reg;
    logic [47:0] last_send_t_reg, last_arr_t_reg, al_end_reg, last_pn_reg;
    logic        al_flag_reg;
    logic [SLOT_COUNT-1:0] busy_reg;

    logic [47:0] m_sent [SLOT_COUNT];
    logic [47:0] m_acked [SLOT_COUNT];
    logic        m_al [SLOT_COUNT];
    logic [47:0] m_sal [SLOT_COUNT];
    logic [47:0] m_lst [SLOT_COUNT];
    logic [47:0] m_lat [SLOT_COUNT];

    logic [47:0] r_sent, r_acked, r_sal, r_lst, r_lat;
    logic        r_al;

    logic [215:0] in_reg;
    logic [1:0]   op;
    logic [SW-1:0] slot;
    logic [SW-1:0] rd_slot;
    logic [47:0]  pn, tsend, tack;
    logic [15:0]  size;
    logic         idle;
    drs_pkg::job_t job_reg, job_next;

    assign op      = in_reg[1:0];
    assign slot    = slot_of(in_reg[9:2]);
    assign rd_slot = slot_of(s_tdata[9:2]);
    assign pn      = in_reg[57:10];
    assign size    = in_reg[73:58];
    assign tsend   = in_reg[121:74];
    assign tack    = in_reg[169:122];
    assign idle    = in_reg[170];

    assign s_tready  = (state_reg == S_IDLE);
    assign job_valid = (state_reg == S_PUSH);
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= s_tdata;
        end
        if (state_reg == S_IDLE) begin
            r_sent  <= m_sent[rd_slot];
            r_acked <= m_acked[rd_slot];
            r_al    <= m_al[rd_slot];
            r_sal   <= m_sal[rd_slot];
            r_lst   <= m_lst[rd_slot];
            r_lat   <= m_lat[rd_slot];
        end
    end

    logic        busy;
    logic [47:0] new_sent, new_acked, ack_bytes;
    assign busy      = busy_reg[slot];
    assign new_sent  = sent_tot_reg + {32'd0, size};
    assign new_acked = acked_tot_reg + {32'd0, size};
    assign ack_bytes = new_acked - r_acked;

    always_comb begin
        job_next = '0;
        job_next.status = drs_pkg::ST_OK;
        case (op)
            drs_pkg::OP_SENT: begin
                if (busy) begin
                    job_next.status = drs_pkg::ST_BUSY;
                end
            end
            drs_pkg::OP_ACKED, drs_pkg::OP_LOST: begin
                if (!busy) begin
                    job_next.status = drs_pkg::ST_EMPTY;
                end else if (op == drs_pkg::OP_ACKED && r_lst != 48'd0 && tack > r_lat) begin
                    job_next.need_rate  = 1'b1;
                    job_next.send_inf   = !(tsend > r_lst);
                    job_next.send_bytes = r_sent - r_sal;
                    job_next.send_delta = tsend - r_lst;
                    job_next.ack_bytes  = ack_bytes;
                    job_next.ack_delta  = tack - r_lat;
                    job_next.rtt        = (tack > tsend) ? tack - tsend : 48'd0;
                    job_next.app_lim    = r_al;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_READ) begin
            job_reg <= job_next;
            if (op == drs_pkg::OP_SENT && !busy) begin
                m_sent[slot]  <= new_sent;
                m_acked[slot] <= acked_tot_reg;
                m_al[slot]    <= al_flag_reg;
                m_sal[slot]   <= idle ? new_sent : sent_at_ack_reg;
                m_lst[slot]   <= idle ? tsend : last_send_t_reg;
                m_lat[slot]   <= idle ? tsend : last_arr_t_reg;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_READ;
            S_READ: state_next = S_PUSH;
            S_PUSH: if (job_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            sent_tot_reg    <= '0;
            acked_tot_reg   <= '0;
            lost_tot_reg    <= '0;
            sent_at_ack_reg <= '0;
            last_send_t_reg <= '0;
            last_arr_t_reg  <= '0;
            al_flag_reg     <= 1'b1;
            al_end_reg      <= '0;
            last_pn_reg     <= '0;
            busy_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_READ) begin
                case (op)
                    drs_pkg::OP_SENT: begin
                        if (!busy) begin
                            last_pn_reg    <= pn;
                            sent_tot_reg   <= new_sent;
                            busy_reg[slot] <= 1'b1;
                            if (idle) begin
                                last_arr_t_reg  <= tsend;
                                sent_at_ack_reg <= new_sent;
                                last_send_t_reg <= tsend;
                            end
                        end
                    end
                    drs_pkg::OP_ACKED: begin
                        if (busy) begin
                            acked_tot_reg   <= new_acked;
                            sent_at_ack_reg <= r_sent;
                            last_send_t_reg <= tsend;
                            last_arr_t_reg  <= tack;
                            if (al_flag_reg && pn > al_end_reg) begin
                                al_flag_reg <= 1'b0;
                            end
                            busy_reg[slot] <= 1'b0;
                        end
                    end
                    drs_pkg::OP_LOST: begin
                        if (busy) begin
                            lost_tot_reg   <= lost_tot_reg + {32'd0, size};
                            busy_reg[slot] <= 1'b0;
                        end
                    end
                    default: begin
                        al_flag_reg <= 1'b1;
                        al_end_reg  <= last_pn_reg;
                    end
                endcase
            end
        end
    end
endmodule

>>> rtl/drs_queue.sv
// ----------------------------------------------------------------------------
// drs_queue: two-entry queue of jobs between the front and the back part.
// ----------------------------------------------------------------------------
module drs_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  drs_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output drs_pkg::job_t out_job
);
    drs_pkg::job_t mem [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop) rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> rtl/drs_back.sv
// ----------------------------------------------------------------------------
// drs_back: forms the send and ack rates with one serial divider and
// holds the result word until it is taken.
// ----------------------------------------------------------------------------
module drs_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  drs_pkg::job_t job,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata
);
    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_MUL  = 5'b00010,
        B_DIV  = 5'b00100,
        B_NEXT = 5'b01000,
        B_OUT  = 5'b10000
    } bstate_t;

    bstate_t state_reg, state_next;
    drs_pkg::job_t job_reg;
    logic        pass_reg;
    logic [71:0] num_reg;
    logic [47:0] den_reg;
    logic [48:0] rem_reg;
    logic [47:0] q_reg, srate_reg;
    logic [6:0]  cnt_reg;
    logic [103:0] out_reg;

    logic [47:0] bytes_sel;
    logic [71:0] prod;
    logic [48:0] rem_sh;
    logic        ge;
    logic [48:0] q_sh;
    logic [47:0] q_new, bw;

    assign bytes_sel = pass_reg ? job_reg.ack_bytes : job_reg.send_bytes;
    assign prod   = {24'd0, bytes_sel} * {48'd0, drs_pkg::BitsPerSec};
    assign rem_sh = {rem_reg[47:0], num_reg[71]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign q_sh   = {q_reg, ge};
    assign q_new  = q_sh[48] ? drs_pkg::Mask48 : q_sh[47:0];
    assign bw     = (srate_reg < q_reg) ? srate_reg : q_reg;

    assign job_ready = (state_reg == B_IDLE);
    assign m_tvalid  = (state_reg == B_OUT);
    assign m_tdata   = out_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (job_valid) state_next = job.need_rate ? B_MUL : B_OUT;
            B_MUL:  state_next = B_DIV;
            B_DIV:  if (cnt_reg == 7'd71) state_next = B_NEXT;
            B_NEXT: state_next = pass_reg ? B_OUT : B_MUL;
            B_OUT:  if (m_tready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                job_reg  <= job;
                pass_reg <= job.send_inf;
                out_reg  <= {4'd0, 1'b0, 48'd0, 48'd0, 1'b0, job.status};
            end
            B_MUL: begin
                num_reg <= prod;
                den_reg <= pass_reg ? job_reg.ack_delta : job_reg.send_delta;
                rem_reg <= '0;
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            B_DIV: begin
                rem_reg <= ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                num_reg <= {num_reg[70:0], 1'b0};
                q_reg   <= q_new;
                cnt_reg <= cnt_reg + 7'd1;
            end
            B_NEXT: begin
                if (!pass_reg) begin
                    srate_reg <= q_reg;
                    pass_reg  <= 1'b1;
                end else begin
                    if (job_reg.send_inf) srate_reg <= drs_pkg::Mask48;
                    out_reg <= {4'd0, job_reg.app_lim, job_reg.rtt,
                                (job_reg.send_inf ? q_reg : bw), 1'b1, job_reg.status};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

>>> rtl/delivery_rate_sampler.sv
// ----------------------------------------------------------------------------
// delivery_rate_sampler: delivery-rate sampler for congestion control.
// ----------------------------------------------------------------------------
// Every input word gives exactly one result word. A front part reads the
// slot store and classifies the event; a two-entry queue passes jobs to a
// back part. Sends, losses, errors and acks without a sample skip the
// divider; an ack with a sample runs the 72-step bit-serial divider once
// per rate, or only once when the send rate is infinite.
module delivery_rate_sampler #(
    parameter int SLOT_COUNT = drs_pkg::SlotCountDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, slot_index, packet_number, packet_size, send_time_us,
    // ack_time_us, nothing_in_flight
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, sample_valid, bandwidth_bps, rtt_us, sample_app_limited
    output logic [103:0] m_tdata
);
    logic          fj_valid, fj_ready, bj_valid, bj_ready;
    drs_pkg::job_t fj, bj;

    drs_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata({40'd0, s_tdata}),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    drs_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
        .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
    );

    drs_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    a_no_sample_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[103:3] == '0))
        else $error("fields set without a sample");

    a_sample_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == drs_pkg::ST_OK))
        else $error("sample with error status");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");
endmodule
